[rtl/core/kab_pkg.sv]
// Package for the angle and gyro bias filter: widths, defaults, codes and shared types.
`timescale 1ns / 1ps
`default_nettype none
package kab_pkg;

	// Field widths
	localparam int DATA_WIDTH_DEF = 32;
	localparam int MEAS_W  = 25;
	localparam int GYRO_W  = 28;
	localparam int DT_W    = 24;
	localparam int NOISE_W = 24;
	localparam int OUT_W   = 26;
	localparam int FRAC_W  = 24;
	localparam int GAIN_W  = 32;
	localparam int CFG_IDX_W = 2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_NOISE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BIAS_NOISE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE  = 2'd2;

	// Register defaults (Q0.24)
	localparam logic [NOISE_W-1:0] ANGLE_NOISE_RST = 24'd16777;
	localparam logic [NOISE_W-1:0] BIAS_NOISE_RST  = 24'd50332;
	localparam logic [NOISE_W-1:0] MEAS_NOISE_RST  = 24'd503316;

	// Output limit of +-360 degrees in Q10.16
	localparam logic signed [OUT_W-1:0] OUT_MAX = 26'sd23592960;
	// Largest gain magnitude
	localparam logic [GAIN_W-2:0] GAIN_MAX = '1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RATE,
		ST_MSTART,
		ST_MWAIT,
		ST_SUM,
		ST_DSTART,
		ST_DWAIT,
		ST_EMIT
	} ctrl_state_t;

	// Products of one filter step, in the order they are formed
	typedef enum logic [3:0] {
		MS_ANGLE_PRED,
		MS_T,
		MS_P00_PRED,
		MS_P11_PRED,
		MS_ANGLE_COR,
		MS_BIAS_COR,
		MS_P00_COR,
		MS_P01_COR,
		MS_P10_COR,
		MS_P11_COR
	} mul_step_t;

	typedef struct packed {
		logic      load;
		logic      rate;
		logic      mul_start;
		logic      mul_wb;
		logic      sum;
		logic      div_start;
		logic      div_wb;
		logic      div_sel;
		logic      emit;
		mul_step_t step;
	} dp_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic s_invalid;
		logic out_free;
	} dp_status_t;

	function automatic mul_step_t next_step(input mul_step_t s);
		mul_step_t n;
		unique case (s)
			MS_ANGLE_PRED: n = MS_T;
			MS_T:          n = MS_P00_PRED;
			MS_P00_PRED:   n = MS_P11_PRED;
			MS_P11_PRED:   n = MS_ANGLE_COR;
			MS_ANGLE_COR:  n = MS_BIAS_COR;
			MS_BIAS_COR:   n = MS_P00_COR;
			MS_P00_COR:    n = MS_P01_COR;
			MS_P01_COR:    n = MS_P10_COR;
			MS_P10_COR:    n = MS_P11_COR;
			MS_P11_COR:    n = MS_ANGLE_PRED;
			default:       n = MS_ANGLE_PRED;
		endcase
		return n;
	endfunction

endpackage
`default_nettype wire

[rtl/core/kab_if.sv]
// Channel interfaces for samples in and filtered angles out.
`timescale 1ns / 1ps
`default_nettype none
interface kab_in_if;
	import kab_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [MEAS_W-1:0] measured_angle;
	logic signed [GYRO_W-1:0] gyro_rate;
	logic        [DT_W-1:0]   time_step;
	modport source (output valid, measured_angle, gyro_rate, time_step, input ready);
	modport sink   (input valid, measured_angle, gyro_rate, time_step, output ready);
endinterface

interface kab_out_if;
	import kab_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] filtered_angle;
	logic                    gain_invalid;
	modport source (output valid, filtered_angle, gain_invalid, input ready);
	modport sink   (input valid, filtered_angle, gain_invalid, output ready);
endinterface
`default_nettype wire

[rtl/core/kalman_angle_bias_filter.sv]
// Top level of the two-state angle and gyro bias filter.
//
// Samples (accelerometer angle, gyro rate, time step) arrive on the sample
// channel; each accepted transaction runs one predict and correct step and
// yields one transaction on the result channel: the filtered angle, clamped
// to +-360 degrees, and a flag set when the correction was skipped.
// Noise settings are to be written over the cfg port only while the block is
// idle; the block does not enforce this. A full step runs the bit-serial gain
// divider twice at 31 quotient bits each, unless the quotient saturates, and
// uses the shared multiplier for its ten products. With a skipped correction
// the step ends after the prediction.
// One sample is worked on at a time; a new sample is taken as soon as the
// previous result sits in the output register, even while it waits there.
// If the receiver stalls, the next result holds until the register is free.
// Reset zeroes the angle, bias and covariance and restores default noise.
`timescale 1ns / 1ps
`default_nettype none
module kalman_angle_bias_filter #(
	parameter int DATA_WIDTH = kab_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	kab_in_if.sink                             sample,
	kab_out_if.source                          result,
	input  wire logic                          cfg_we,
	input  wire logic [kab_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [kab_pkg::NOISE_W-1:0]   cfg_data
);
	import kab_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	kab_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.status   (status),
		.cmd      (cmd)
	);

	kab_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.measured_angle (sample.measured_angle),
		.gyro_rate      (sample.gyro_rate),
		.time_step      (sample.time_step),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_valid      (result.valid),
		.out_ready      (result.ready),
		.filtered_angle (result.filtered_angle),
		.gain_invalid   (result.gain_invalid)
	);
endmodule
`default_nettype wire

[rtl/core/kab_mul.sv]
// Shared signed multiplier: short by long operand in two passes, product shifted right 24.
`timescale 1ns / 1ps
`default_nettype none
module kab_mul #(
	parameter int LW = kab_pkg::DATA_WIDTH_DEF + 2
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic signed [32:0]   a,
	input  wire logic signed [LW-1:0] b,
	output logic                      done,
	output logic signed [LW+8:0]      m
);
	import kab_pkg::*;

	localparam int LH = (LW + 1) / 2;
	localparam int PW = 32 + LW;

	logic [31:0]        am_q;
	logic [LW-1:0]      bm_q;
	logic               neg_q;
	logic               busy_q;
	logic               ph_q;
	logic [32+LH-1:0]   lo_q;
	logic signed [LW+8:0] res_q;
	logic               done_q;

	logic [32:0]   a_mag;
	logic [LW-1:0] b_mag;
	logic [PW-1:0] full;
	logic [LW+7:0] mag;

	assign a_mag = a[32] ? 33'(-a) : 33'(a);
	assign b_mag = b[LW-1] ? LW'(-b) : LW'(b);

	// second pass adds the upper partial product
	assign full = PW'(lo_q) + (PW'(am_q * bm_q[LW-1:LH]) << LH);
	assign mag  = full[PW-1:FRAC_W];

	// pass sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				ph_q   <= 1'b0;
			end else if (busy_q) begin
				if (ph_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				ph_q <= ~ph_q;
			end
		end
	end

	// operand and product registers
	always_ff @(posedge clk) begin
		if (start) begin
			am_q  <= a_mag[31:0];
			bm_q  <= b_mag;
			neg_q <= a[32] ^ b[LW-1];
		end else if (busy_q && !ph_q) begin
			lo_q <= am_q * bm_q[LH-1:0];
		end else if (busy_q && ph_q) begin
			res_q <= neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		end
	end

	assign done = done_q;
	assign m    = res_q;
endmodule
`default_nettype wire

[rtl/core/kab_div.sv]
// Bit-serial gain divider: signed num / den in Q8.24, one quotient bit a cycle, saturated.
`timescale 1ns / 1ps
`default_nettype none
module kab_div #(
	parameter int DW = kab_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic signed [DW-1:0] num,
	input  wire logic [DW:0]          den,
	output logic                      done,
	output logic signed [kab_pkg::GAIN_W-1:0] k
);
	import kab_pkg::*;

	localparam int NW = DW + 31;
	localparam int QB = GAIN_W - 1;

	logic [NW-1:0]  r_q;
	logic [NW-1:0]  dd_q;
	logic [QB-1:0]  q_q;
	logic [4:0]     cnt_q;
	logic           busy_q;
	logic           neg_q;
	logic           done_q;
	logic signed [GAIN_W-1:0] k_q;

	logic [DW-1:0] u;
	logic          big;
	logic          bit_set;
	logic [QB-1:0] q_next;

	assign u       = num[DW-1] ? DW'(-num) : DW'(num);
	// quotient of 128 or more saturates at once
	assign big     = (DW+8)'(u) >= ((DW+8)'(den) << 7);
	assign bit_set = r_q >= dd_q;
	assign q_next  = {q_q[QB-2:0], bit_set};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= !big;
				done_q <= big;
				cnt_q  <= 5'd31;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division with a divisor that shifts down
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[DW-1];
			r_q   <= NW'(u) << FRAC_W;
			dd_q  <= NW'(den) << 30;
			q_q   <= '0;
			if (big)
				k_q <= num[DW-1] ? -$signed({1'b0, GAIN_MAX}) : $signed({1'b0, GAIN_MAX});
		end else if (busy_q) begin
			if (bit_set)
				r_q <= r_q - dd_q;
			dd_q <= dd_q >> 1;
			q_q  <= q_next;
			if (cnt_q == 5'd1)
				k_q <= neg_q ? -$signed({1'b0, q_next}) : $signed({1'b0, q_next});
		end
	end

	assign done = done_q;
	assign k    = k_q;
endmodule
`default_nettype wire

[rtl/core/kab_datapath.sv]
// Filter datapath: state, configuration, operand selection, write-back and output register.
`timescale 1ns / 1ps
`default_nettype none
module kab_datapath #(
	parameter int DATA_WIDTH = kab_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire kab_pkg::dp_cmd_t                  cmd,
	output kab_pkg::dp_status_t                    status,
	input  wire logic signed [kab_pkg::MEAS_W-1:0] measured_angle,
	input  wire logic signed [kab_pkg::GYRO_W-1:0] gyro_rate,
	input  wire logic [kab_pkg::DT_W-1:0]          time_step,
	input  wire logic                              cfg_we,
	input  wire logic [kab_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [kab_pkg::NOISE_W-1:0]       cfg_data,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [kab_pkg::OUT_W-1:0]       filtered_angle,
	output logic                                   gain_invalid
);
	import kab_pkg::*;

	localparam int DW = DATA_WIDTH;
	localparam int LW = DW + 2;
	localparam int RW = LW + 9;
	localparam int SW = RW + 1;

	localparam logic signed [SW-1:0] DMAX = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [SW-1:0] DMIN = ~DMAX;

	function automatic logic signed [DW-1:0] sat_dw(input logic signed [SW-1:0] v);
		logic signed [DW-1:0] r;
		if (v > DMAX)
			r = $signed(DMAX[DW-1:0]);
		else if (v < DMIN)
			r = $signed(DMIN[DW-1:0]);
		else
			r = $signed(v[DW-1:0]);
		return r;
	endfunction

	// configuration
	logic [NOISE_W-1:0] qa_q, qb_q, rm_q;
	// filter state
	logic signed [DW-1:0] angle_q, bias_q, p0_q, p1_q, p2_q, p3_q;
	// per-sample working values
	logic signed [MEAS_W-1:0] meas_q;
	logic signed [GYRO_W-1:0] gyro_q;
	logic [DT_W-1:0]          dt_q;
	logic signed [DW-1:0]     rate_q, p00_q, p01_q;
	logic signed [LW-1:0]     inner_q, y_q;
	logic signed [DW+1:0]     s_q;
	logic signed [GAIN_W-1:0] k0_q, k1_q;
	logic                     invalid_q;
	// output register
	logic                     out_valid_q;
	logic signed [OUT_W-1:0]  filt_q;
	logic                     ginv_q;

	logic signed [32:0]     mul_a;
	logic signed [LW-1:0]   mul_b;
	logic                   mul_done;
	logic signed [RW-1:0]   mul_m;
	logic signed [SW-1:0]   mx;
	logic signed [DW-1:0]   div_num;
	logic                   div_done;
	logic signed [GAIN_W-1:0] div_k;
	logic signed [DW+1:0]   s_calc;
	logic signed [SW-1:0]   inner_calc;
	logic signed [SW-1:0]   ang_ext, ang_clamp;

	// operand selection per product
	always_comb begin
		mul_a = 33'($signed({1'b0, dt_q}));
		mul_b = LW'(rate_q);
		case (cmd.step)
			MS_ANGLE_PRED: begin mul_a = 33'($signed({1'b0, dt_q})); mul_b = LW'(rate_q); end
			MS_T:          begin mul_a = 33'($signed({1'b0, dt_q})); mul_b = LW'(p3_q); end
			MS_P00_PRED:   begin mul_a = 33'($signed({1'b0, dt_q})); mul_b = inner_q; end
			MS_P11_PRED:   begin
				mul_a = 33'($signed({1'b0, qb_q}));
				mul_b = LW'($signed({1'b0, dt_q}));
			end
			MS_ANGLE_COR:  begin mul_a = 33'(k0_q); mul_b = y_q; end
			MS_BIAS_COR:   begin mul_a = 33'(k1_q); mul_b = y_q; end
			MS_P00_COR:    begin mul_a = 33'(k0_q); mul_b = LW'(p00_q); end
			MS_P01_COR:    begin mul_a = 33'(k0_q); mul_b = LW'(p01_q); end
			MS_P10_COR:    begin mul_a = 33'(k1_q); mul_b = LW'(p00_q); end
			MS_P11_COR:    begin mul_a = 33'(k1_q); mul_b = LW'(p01_q); end
			default:       ;
		endcase
	end

	kab_mul #(.LW(LW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.m      (mul_m)
	);

	assign div_num = cmd.div_sel ? p2_q : p0_q;

	kab_div #(.DW(DW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (s_q[DW:0]),
		.done   (div_done),
		.k      (div_k)
	);

	assign mx         = SW'(mul_m);
	assign inner_calc = mx - SW'(p1_q) - SW'(p2_q) + SW'($signed({1'b0, qa_q}));
	assign s_calc     = (DW+2)'(p0_q) + (DW+2)'($signed({1'b0, rm_q}));

	// output clamp to +-360 degrees
	assign ang_ext = SW'(angle_q);
	always_comb begin
		if (ang_ext > SW'(OUT_MAX))
			ang_clamp = SW'(OUT_MAX);
		else if (ang_ext < -SW'(OUT_MAX))
			ang_clamp = -SW'(OUT_MAX);
		else
			ang_clamp = ang_ext;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qa_q <= ANGLE_NOISE_RST;
			qb_q <= BIAS_NOISE_RST;
			rm_q <= MEAS_NOISE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ANGLE_NOISE: qa_q <= cfg_data;
				CFG_BIAS_NOISE:  qb_q <= cfg_data;
				CFG_MEAS_NOISE:  rm_q <= cfg_data;
				default:         ;
			endcase
		end
	end

	// filter state and write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= '0;
			bias_q  <= '0;
			p0_q    <= '0;
			p1_q    <= '0;
			p2_q    <= '0;
			p3_q    <= '0;
		end else if (cmd.mul_wb) begin
			case (cmd.step)
				MS_ANGLE_PRED: angle_q <= sat_dw(SW'(angle_q) + mx);
				MS_T: begin
					p1_q <= sat_dw(SW'(p1_q) - mx);
					p2_q <= sat_dw(SW'(p2_q) - mx);
				end
				MS_P00_PRED:   p0_q    <= sat_dw(SW'(p0_q) + mx);
				MS_P11_PRED:   p3_q    <= sat_dw(SW'(p3_q) + mx);
				MS_ANGLE_COR:  angle_q <= sat_dw(SW'(angle_q) + mx);
				MS_BIAS_COR:   bias_q  <= sat_dw(SW'(bias_q) + mx);
				MS_P00_COR:    p0_q    <= sat_dw(SW'(p0_q) - mx);
				MS_P01_COR:    p1_q    <= sat_dw(SW'(p1_q) - mx);
				MS_P10_COR:    p2_q    <= sat_dw(SW'(p2_q) - mx);
				MS_P11_COR:    p3_q    <= sat_dw(SW'(p3_q) - mx);
				default:       ;
			endcase
		end
	end

	// per-sample working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			meas_q    <= measured_angle;
			gyro_q    <= gyro_rate;
			dt_q      <= time_step;
			invalid_q <= 1'b0;
		end
		if (cmd.rate)
			rate_q <= sat_dw(SW'(gyro_q) - SW'(bias_q));
		if (cmd.mul_wb && cmd.step == MS_T)
			inner_q <= LW'(inner_calc);
		if (cmd.sum) begin
			s_q       <= s_calc;
			invalid_q <= status.s_invalid;
			y_q       <= LW'(meas_q) - LW'(angle_q);
			p00_q     <= p0_q;
			p01_q     <= p1_q;
		end
		if (cmd.div_wb) begin
			if (cmd.div_sel)
				k1_q <= div_k;
			else
				k0_q <= div_k;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			filt_q <= OUT_W'(ang_clamp);
			ginv_q <= invalid_q;
		end
	end

	assign status.mul_done  = mul_done;
	assign status.div_done  = div_done;
	assign status.s_invalid = s_calc[DW+1] || (s_calc == '0);
	assign status.out_free  = !out_valid_q || out_ready;

	assign out_valid      = out_valid_q;
	assign filtered_angle = filt_q;
	assign gain_invalid   = ginv_q;
endmodule
`default_nettype wire

[rtl/core/kab_ctrl.sv]
// Filter sequencer: steps prediction, gain division and correction over the shared units.
`timescale 1ns / 1ps
`default_nettype none
module kab_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire kab_pkg::dp_status_t status,
	output kab_pkg::dp_cmd_t         cmd
);
	import kab_pkg::*;

	ctrl_state_t state_q, state_d;
	mul_step_t   step_q, step_d;
	logic        sel_q, sel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= MS_ANGLE_PRED;
			sel_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			sel_q   <= sel_d;
		end
	end

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		sel_d   = sel_q;
		cmd     = '0;
		cmd.step    = step_q;
		cmd.div_sel = sel_q;
		in_ready    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_RATE;
				end
			end
			ST_RATE: begin
				cmd.rate = 1'b1;
				step_d   = MS_ANGLE_PRED;
				state_d  = ST_MSTART;
			end
			ST_MSTART: begin
				cmd.mul_start = 1'b1;
				state_d       = ST_MWAIT;
			end
			ST_MWAIT: begin
				if (status.mul_done) begin
					cmd.mul_wb = 1'b1;
					step_d     = next_step(step_q);
					if (step_q == MS_P11_PRED)
						state_d = ST_SUM;
					else if (step_q == MS_P11_COR)
						state_d = ST_EMIT;
					else
						state_d = ST_MSTART;
				end
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				sel_d   = 1'b0;
				state_d = status.s_invalid ? ST_EMIT : ST_DSTART;
			end
			ST_DSTART: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DWAIT;
			end
			ST_DWAIT: begin
				if (status.div_done) begin
					cmd.div_wb = 1'b1;
					if (sel_q) begin
						state_d = ST_MSTART;
					end else begin
						sel_d   = 1'b1;
						state_d = ST_DSTART;
					end
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire
